// File: rtl/ctl_pkg.sv
`timescale 1ns / 1ps
package ctl_pkg;

    localparam int CTL_POSITION_BITS = 16;
    localparam int CTL_MAX_RESULTS   = 4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [2:0]  token_class;
        logic [5:0]  operator_code;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        last_of_run;
    } t_out;

    // all results caused by one input character
    typedef struct packed {
        logic [2:0]                       count;
        t_out [CTL_MAX_RESULTS-1:0]       recs;
    } t_bundle;

    typedef enum logic [2:0] {
        CLS_WORD     = 3'd0,
        CLS_DECIMAL  = 3'd1,
        CLS_OCTAL    = 3'd2,
        CLS_HEX      = 3'd3,
        CLS_FLOAT    = 3'd4,
        CLS_SIZEOF   = 3'd5,
        CLS_OPERATOR = 3'd6,
        CLS_INVALID  = 3'd7
    } t_tok_class;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_WORD      = 4'd1,
        PH_NUM       = 4'd2,
        PH_ZERO_X    = 4'd3,
        PH_HEX       = 4'd4,
        PH_DOT_PEND  = 4'd5,
        PH_FRAC      = 4'd6,
        PH_E_PEND    = 4'd7,
        PH_SIGN_PEND = 4'd8,
        PH_EXP       = 4'd9,
        PH_OPS       = 4'd10,
        PH_BAD       = 4'd11
    } t_phase;

    typedef enum logic [5:0] {
        OP_LPAREN, OP_RPAREN, OP_LBRACK, OP_RBRACK, OP_DOT, OP_TILDE, OP_QUEST,
        OP_COLON, OP_COMMA, OP_NOT, OP_NE, OP_XOR, OP_XOR_EQ, OP_DIV, OP_DIV_EQ,
        OP_ASSIGN, OP_EQ, OP_MUL, OP_MUL_EQ, OP_MOD_EQ, OP_OR, OP_LOR, OP_OR_EQ,
        OP_ADD, OP_INC, OP_ADD_EQ, OP_AND, OP_LAND, OP_AND_EQ, OP_SUB, OP_ARROW,
        OP_DEC, OP_SUB_EQ, OP_GT, OP_SHR_EQ, OP_SHR, OP_GE, OP_LT, OP_SHL_EQ,
        OP_SHL, OP_LE
    } t_op_code;

endpackage

// File: rtl/ctl_front.sv
`timescale 1ns / 1ps
module ctl_front import ctl_pkg::*; #(
    parameter int POSITION_BITS = CTL_POSITION_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in     i_in_data,
    input  logic    i_full,
    output logic    o_push,
    output t_bundle o_bundle
);

    typedef logic [POSITION_BITS-1:0] t_pos;
    localparam t_pos POS_MAX = '1;

    typedef struct packed {
        t_phase          phase;
        logic [2:0][7:0] la;
        logic [1:0]      la_cnt;
        t_pos            held_pos;
        t_pos            cur_start;
        logic [15:0]     tok_len;
        logic            oct_ok;
        logic [2:0]      sz_cnt;
    } t_lex_st;

    typedef struct packed {
        t_lex_st st;
        t_bundle bnd;
    } t_work;

    typedef struct packed {
        logic       found;
        t_op_code   code;
        logic [1:0] len;
    } t_op_hit;

    t_lex_st r_st, n_st;
    t_pos    r_pos, n_pos;
    t_bundle w_bundle;
    logic    w_accept;

    function automatic logic is_space(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_op(logic [7:0] c);
        return c == "(" || c == ")" || c == "[" || c == "]" || c == "." || c == "-" ||
               c == "," || c == "!" || c == "~" || c == ">" || c == "<" || c == "^" ||
               c == "|" || c == "+" || c == "/" || c == "&" || c == "?" || c == ":" ||
               c == "=" || c == "%" || c == "*";
    endfunction

    function automatic logic [7:0] f_kw(logic [2:0] n);
        case (n)
            3'd1:    return "i";
            3'd2:    return "z";
            3'd3:    return "e";
            3'd4:    return "o";
            3'd5:    return "f";
            default: return "s";
        endcase
    endfunction

    function automatic t_pos f_pos_add(t_pos p, logic [1:0] k);
        logic [POSITION_BITS:0] s;
        s = {1'b0, p} + (POSITION_BITS+1)'(k);
        return s[POSITION_BITS] ? POS_MAX : s[POSITION_BITS-1:0];
    endfunction

    function automatic logic [15:0] f_len_add(logic [15:0] l, logic [1:0] k);
        logic [16:0] s;
        s = {1'b0, l} + 17'(k);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic t_op_hit f_op_match(logic [2:0][7:0] la, logic [1:0] n);
        t_op_hit h;
        h = '{found: 1'b0, code: OP_LPAREN, len: 2'd0};
        if (n == 2'd3 && {la[0], la[1], la[2]} == ">>=") begin
            h = '{found: 1'b1, code: OP_SHR_EQ, len: 2'd3};
        end else if (n == 2'd3 && {la[0], la[1], la[2]} == "<<=") begin
            h = '{found: 1'b1, code: OP_SHL_EQ, len: 2'd3};
        end else begin
            if (n >= 2'd2) begin
                h.found = 1'b1;
                h.len   = 2'd2;
                case ({la[0], la[1]})
                    "!=":    h.code = OP_NE;
                    "^=":    h.code = OP_XOR_EQ;
                    "/=":    h.code = OP_DIV_EQ;
                    "==":    h.code = OP_EQ;
                    "*=":    h.code = OP_MUL_EQ;
                    "%=":    h.code = OP_MOD_EQ;
                    "||":    h.code = OP_LOR;
                    "|=":    h.code = OP_OR_EQ;
                    "++":    h.code = OP_INC;
                    "+=":    h.code = OP_ADD_EQ;
                    "&&":    h.code = OP_LAND;
                    "&=":    h.code = OP_AND_EQ;
                    "->":    h.code = OP_ARROW;
                    "--":    h.code = OP_DEC;
                    "-=":    h.code = OP_SUB_EQ;
                    ">>":    h.code = OP_SHR;
                    ">=":    h.code = OP_GE;
                    "<<":    h.code = OP_SHL;
                    "<=":    h.code = OP_LE;
                    default: h.found = 1'b0;
                endcase
            end
            if (!h.found && n >= 2'd1) begin
                h.found = 1'b1;
                h.len   = 2'd1;
                case (la[0])
                    "(":     h.code = OP_LPAREN;
                    ")":     h.code = OP_RPAREN;
                    "[":     h.code = OP_LBRACK;
                    "]":     h.code = OP_RBRACK;
                    ".":     h.code = OP_DOT;
                    "~":     h.code = OP_TILDE;
                    "?":     h.code = OP_QUEST;
                    ":":     h.code = OP_COLON;
                    ",":     h.code = OP_COMMA;
                    "!":     h.code = OP_NOT;
                    "^":     h.code = OP_XOR;
                    "/":     h.code = OP_DIV;
                    "=":     h.code = OP_ASSIGN;
                    "*":     h.code = OP_MUL;
                    "|":     h.code = OP_OR;
                    "+":     h.code = OP_ADD;
                    "&":     h.code = OP_AND;
                    "-":     h.code = OP_SUB;
                    ">":     h.code = OP_GT;
                    "<":     h.code = OP_LT;
                    default: h.found = 1'b0;
                endcase
            end
        end
        return h;
    endfunction

    // records beyond the fourth are dropped
    function automatic t_work f_emit(t_work wi, t_tok_class cls, t_op_code op, t_pos st,
                                     logic [15:0] len);
        t_work w;
        t_out  r;
        w = wi;
        r.token_class   = cls;
        r.operator_code = op;
        r.token_start   = (32'(st) > 32'h0000_FFFF) ? 16'hFFFF : 16'(32'(st));
        r.token_length  = len;
        r.last_of_run   = 1'b0;
        if (w.bnd.count < 3'(CTL_MAX_RESULTS)) begin
            w.bnd.recs[w.bnd.count[1:0]] = r;
            w.bnd.count = w.bnd.count + 3'd1;
        end
        return w;
    endfunction

    function automatic t_work f_go_idle(t_work wi);
        t_work w;
        w = wi;
        w.st.phase  = PH_IDLE;
        w.st.la_cnt = 2'd0;
        w.st.sz_cnt = 3'd0;
        return w;
    endfunction

    function automatic t_tok_class f_num_class(t_phase ph, logic oct);
        case (ph)
            PH_HEX:                                     return CLS_HEX;
            PH_FRAC, PH_E_PEND, PH_SIGN_PEND, PH_EXP:   return CLS_FLOAT;
            default:                                    return oct ? CLS_OCTAL : CLS_DECIMAL;
        endcase
    endfunction

    function automatic logic f_pending(t_phase ph);
        return ph == PH_ZERO_X || ph == PH_DOT_PEND || ph == PH_E_PEND || ph == PH_SIGN_PEND;
    endfunction

    function automatic logic f_continues(t_phase ph, logic [7:0] c);
        case (ph)
            PH_ZERO_X:    return is_hex(c);
            PH_DOT_PEND:  return is_digit(c);
            PH_E_PEND:    return c == "+" || c == "-";
            PH_SIGN_PEND: return is_digit(c);
            default:      return 1'b1;
        endcase
    endfunction

    function automatic t_work f_start(t_work wi, logic [7:0] c, t_pos pos);
        t_work w;
        w = wi;
        if (!is_space(c)) begin
            w.st.cur_start = pos;
            w.st.tok_len   = 16'd1;
            if (is_letter(c)) begin
                w.st.phase  = PH_WORD;
                w.st.sz_cnt = (c == "s") ? 3'd1 : 3'd0;
            end else if (is_digit(c)) begin
                w.st.phase  = PH_NUM;
                w.st.oct_ok = (c == "0");
            end else if (is_op(c)) begin
                w.st.phase    = PH_OPS;
                w.st.la[0]    = c;
                w.st.la_cnt   = 2'd1;
                w.st.held_pos = pos;
            end else begin
                w.st.phase = PH_BAD;
            end
        end
        return w;
    endfunction

    function automatic t_work f_hold(t_work wi, logic [7:0] c, t_pos pos, t_phase ph);
        t_work w;
        w = wi;
        if (w.st.la_cnt == 2'd0)
            w.st.held_pos = pos;
        if (w.st.la_cnt < 2'd3) begin
            w.st.la[w.st.la_cnt] = c;
            w.st.la_cnt = w.st.la_cnt + 2'd1;
        end
        w.st.phase = ph;
        return w;
    endfunction

    function automatic t_work f_emit_one_op(t_work wi);
        t_work   w;
        t_op_hit h;
        logic [1:0] l;
        w = wi;
        h = f_op_match(w.st.la, w.st.la_cnt);
        if (!h.found) begin
            // lone percent sign; operator code reads as zero
            w = f_emit(w, CLS_INVALID, OP_LPAREN, w.st.held_pos, 16'd1);
            l = 2'd1;
        end else begin
            w = f_emit(w, CLS_OPERATOR, h.code, w.st.held_pos, 16'(h.len));
            l = h.len;
        end
        case (l)
            2'd1:    w.st.la = {8'd0, w.st.la[2], w.st.la[1]};
            2'd2:    w.st.la = {16'd0, w.st.la[2]};
            default: w.st.la = '0;
        endcase
        w.st.la_cnt   = w.st.la_cnt - l;
        w.st.held_pos = f_pos_add(w.st.held_pos, l);
        return w;
    endfunction

    function automatic t_work f_drain(t_work wi);
        t_work w;
        w = wi;
        for (int k = 0; k < 2; k++) begin
            if (w.st.la_cnt != 2'd0)
                w = f_emit_one_op(w);
        end
        return w;
    endfunction

    function automatic t_work f_end_start(t_work wi, t_tok_class cls, logic [7:0] c,
                                          t_pos pos);
        t_work w;
        w = f_emit(wi, cls, OP_LPAREN, wi.st.cur_start, wi.st.tok_len);
        w = f_go_idle(w);
        w = f_start(w, c, pos);
        return w;
    endfunction

    // pending phases reach here only when the character continues them
    function automatic t_work f_feed(t_work wi, logic [7:0] c, t_pos pos);
        t_work w;
        w = wi;
        case (w.st.phase)
            PH_IDLE: w = f_start(w, c, pos);
            PH_WORD: begin
                if (!is_letter(c) && !is_digit(c)) begin
                    w = f_end_start(w, CLS_WORD, c, pos);
                end else begin
                    w.st.tok_len = f_len_add(w.st.tok_len, 2'd1);
                    if (w.st.sz_cnt != 3'd0 && w.st.sz_cnt < 3'd6 &&
                        c == f_kw(w.st.sz_cnt)) begin
                        w.st.sz_cnt = w.st.sz_cnt + 3'd1;
                        if (w.st.sz_cnt == 3'd6) begin
                            w = f_emit(w, CLS_SIZEOF, OP_LPAREN, w.st.cur_start,
                                       w.st.tok_len);
                            w = f_go_idle(w);
                        end
                    end else begin
                        w.st.sz_cnt = 3'd0;
                    end
                end
            end
            PH_NUM: begin
                if (is_digit(c)) begin
                    if (c > "7")
                        w.st.oct_ok = 1'b0;
                    w.st.tok_len = f_len_add(w.st.tok_len, 2'd1);
                end else if (w.st.tok_len == 16'd1 && w.st.oct_ok && (c == "x" || c == "X")) begin
                    w = f_hold(w, c, pos, PH_ZERO_X);
                end else if (c == ".") begin
                    w = f_hold(w, c, pos, PH_DOT_PEND);
                end else begin
                    w = f_end_start(w, f_num_class(w.st.phase, w.st.oct_ok), c, pos);
                end
            end
            PH_ZERO_X: begin
                w.st.tok_len = f_len_add(w.st.tok_len, 2'd2);
                w.st.la_cnt  = 2'd0;
                w.st.phase   = PH_HEX;
            end
            PH_HEX: begin
                if (is_hex(c))
                    w.st.tok_len = f_len_add(w.st.tok_len, 2'd1);
                else
                    w = f_end_start(w, CLS_HEX, c, pos);
            end
            PH_DOT_PEND: begin
                w.st.tok_len = f_len_add(w.st.tok_len, 2'd2);
                w.st.la_cnt  = 2'd0;
                w.st.phase   = PH_FRAC;
            end
            PH_FRAC: begin
                if (is_digit(c))
                    w.st.tok_len = f_len_add(w.st.tok_len, 2'd1);
                else if (c == "e" || c == "E")
                    w = f_hold(w, c, pos, PH_E_PEND);
                else
                    w = f_end_start(w, CLS_FLOAT, c, pos);
            end
            PH_E_PEND: w = f_hold(w, c, pos, PH_SIGN_PEND);
            PH_SIGN_PEND: begin
                w.st.tok_len = f_len_add(w.st.tok_len, 2'd3);
                w.st.la_cnt  = 2'd0;
                w.st.phase   = PH_EXP;
            end
            PH_EXP: begin
                if (is_digit(c))
                    w.st.tok_len = f_len_add(w.st.tok_len, 2'd1);
                else
                    w = f_end_start(w, CLS_FLOAT, c, pos);
            end
            PH_OPS: begin
                if (is_op(c)) begin
                    w = f_hold(w, c, pos, PH_OPS);
                    if (w.st.la_cnt == 2'd3)
                        w = f_emit_one_op(w);
                end else begin
                    w = f_drain(w);
                    w = f_go_idle(w);
                    w = f_start(w, c, pos);
                end
            end
            default: begin
                if (!is_space(c) && !is_letter(c) && !is_digit(c) && !is_op(c))
                    w.st.tok_len = f_len_add(w.st.tok_len, 2'd1);
                else
                    w = f_end_start(w, CLS_INVALID, c, pos);
            end
        endcase
        return w;
    endfunction

    // close a broken number and replay the held characters from idle
    function automatic t_work f_fail(t_work wi);
        t_work           w;
        logic [2:0][7:0] tmp;
        logic [1:0]      n;
        t_pos            base;
        w    = wi;
        tmp  = w.st.la;
        n    = w.st.la_cnt;
        base = w.st.held_pos;
        w = f_emit(w, f_num_class(w.st.phase, w.st.oct_ok), OP_LPAREN, w.st.cur_start,
                   w.st.tok_len);
        w = f_go_idle(w);
        for (int k = 0; k < 2; k++) begin
            if (2'(k) < n)
                w = f_feed(w, tmp[k], f_pos_add(base, 2'(k)));
        end
        return w;
    endfunction

    always_comb begin
        t_work w;
        w.st  = r_st;
        w.bnd = '0;
        if (f_pending(r_st.phase) && !f_continues(r_st.phase, i_in_data.char_code))
            w = f_fail(w);
        w = f_feed(w, i_in_data.char_code, r_pos);
        if (i_in_data.end_of_text) begin
            if (f_pending(w.st.phase))
                w = f_fail(w);
            case (w.st.phase)
                PH_WORD: w = f_emit(w, CLS_WORD, OP_LPAREN, w.st.cur_start, w.st.tok_len);
                PH_NUM, PH_HEX, PH_FRAC, PH_EXP:
                    w = f_emit(w, f_num_class(w.st.phase, w.st.oct_ok), OP_LPAREN,
                               w.st.cur_start, w.st.tok_len);
                PH_OPS:  w = f_drain(w);
                PH_BAD:  w = f_emit(w, CLS_INVALID, OP_LPAREN, w.st.cur_start, w.st.tok_len);
                default: ;
            endcase
            n_st       = '0;
            n_st.phase = PH_IDLE;
            n_pos      = '0;
        end else begin
            n_st  = w.st;
            n_pos = f_pos_add(r_pos, 2'd1);
        end
        if (w.bnd.count != 3'd0)
            w.bnd.recs[2'(w.bnd.count - 3'd1)].last_of_run = 1'b1;
        w_bundle = w.bnd;
    end

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = w_accept && (w_bundle.count != 3'd0);
    assign o_bundle   = w_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= '0;
            r_st.phase <= PH_IDLE;
            r_pos      <= '0;
        end else if (w_accept) begin
            r_st  <= n_st;
            r_pos <= n_pos;
        end
    end

endmodule

// File: rtl/ctl_queue.sv
`timescale 1ns / 1ps
module ctl_queue import ctl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output t_bundle o_data,
    output logic    o_empty,
    output logic    o_full
);

    t_bundle    r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt, n_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop)
            n_cnt = r_cnt + 2'd1;
        else if (!i_push && i_pop)
            n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push)
                r_wr_ptr <= !r_wr_ptr;
            if (i_pop)
                r_rd_ptr <= !r_rd_ptr;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/ctl_back.sv
`timescale 1ns / 1ps
module ctl_back import ctl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bundle i_bundle,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out_data
);

    t_bundle    r_bnd;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       w_last, w_load;

    assign w_last      = ({1'b0, r_idx} == r_bnd.count - 3'd1);
    assign w_load      = !r_busy || (i_out_ready && w_last);
    assign o_pop       = w_load && !i_empty;
    assign o_out_valid = r_busy;
    assign o_out_data  = r_bnd.recs[r_idx];

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_bnd <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (w_load) begin
            r_busy <= !i_empty;
            r_idx  <= 2'd0;
        end else if (i_out_ready) begin
            // advance to the next record of this bundle
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// File: rtl/c_token_lexer.sv
`timescale 1ns / 1ps
// C token lexer: one text character per input transaction, token records out.
// Input channel: i_in_valid / o_in_ready carry char_code and end_of_text.
// Output channel: o_out_valid / i_out_ready carry one token record per
// transaction; last_of_run marks the final record caused by one character.
// A character is taken every cycle while the two-entry bundle queue has room;
// the classifier decides all records of that character in the accepting cycle.
// Each bundle is written into the queue and then loaded into the record stage.
// The record stage sends one record per cycle while the receiver is ready, so a
// character that closes several tokens (up to four) holds the output until all are sent.
// end_of_text flushes pending tokens and returns the scanner to offset zero.
// Reset (synchronous, active low) empties the queue and the record stage and
// puts the scanner between tokens at offset zero.
// When the receiver stalls, the record is held, the queue fills and o_in_ready
// drops after two more bundles.
module c_token_lexer import ctl_pkg::*; #(
    parameter int POSITION_BITS = CTL_POSITION_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_bundle w_push_data, w_pop_data;
    logic    w_push, w_pop, w_empty, w_full;

    ctl_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_bundle   (w_push_data)
    );

    ctl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    ctl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bundle    (w_pop_data),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/ctl_checker.sv
`timescale 1ns / 1ps
module ctl_checker import ctl_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output record dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.token_length != 16'd0)
        else $error("zero length token");

    a_op_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.token_class != CLS_OPERATOR
            |-> o_out_data.operator_code == 6'd0)
        else $error("operator code on non operator token");

    a_op_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.token_class == CLS_OPERATOR
            |-> o_out_data.operator_code <= 6'(OP_LE))
        else $error("operator code out of range");

endmodule

bind c_token_lexer ctl_checker u_chk (.*);
